// ===== rtl/core/sws_pkg.sv =====
// Shared types, constants and character helpers for the seed-weighted alignment scorer.
package sws_pkg;

    // Field and state widths
    localparam int CHAR_W  = 8;
    localparam int CFG_W   = 7;
    localparam int COUNT_W = 7;
    localparam int SCORE_W = 9;
    localparam int COST_W  = 3;

    // Configuration register indexes
    localparam logic CFG_SEED_FIRST = 1'b0;
    localparam logic CFG_SEED_LAST  = 1'b1;

    // Configuration reset values
    localparam logic [CFG_W-1:0] SEED_FIRST_RST = 7'd2;
    localparam logic [CFG_W-1:0] SEED_LAST_RST  = 7'd8;

    // Saturation limits
    localparam logic [COUNT_W-1:0] COUNT_CAP = 7'd127;
    localparam logic [SCORE_W-1:0] SUM_CAP   = 9'd511;

    // Gap marker '-'
    localparam logic [CHAR_W-1:0] GAP_CHAR = 8'h2d;

    // Penalties in halves
    localparam logic [COST_W-1:0] COST_NONE      = 3'd0;
    localparam logic [COST_W-1:0] COST_WOBBLE    = 3'd1;
    localparam logic [COST_W-1:0] COST_WOBBLE_SD = 3'd2;
    localparam logic [COST_W-1:0] COST_MISS      = 3'd2;
    localparam logic [COST_W-1:0] COST_MISS_SD   = 3'd4;

    // Column classification handed from classifier to accumulator
    typedef struct packed {
        logic any_gap;     // either character is a gap
        logic second_gap;  // second sequence has a gap: shifts seed window
        logic match;       // identical base letter
        logic wobble;      // G-A, T-C or U-C pair in one case
    } col_class_t;

    // a c g t u in either case
    function automatic logic is_base(input logic [CHAR_W-1:0] c);
        logic r;
        r = c inside {8'h61, 8'h63, 8'h67, 8'h74, 8'h75,
                      8'h41, 8'h43, 8'h47, 8'h54, 8'h55};
        return r;
    endfunction

    function automatic logic is_wobble(input logic [CHAR_W-1:0] a,
                                       input logic [CHAR_W-1:0] b);
        logic r;
        r = (a == 8'h47 && b == 8'h41) || (a == 8'h67 && b == 8'h61) ||
            (a == 8'h54 && b == 8'h43) || (a == 8'h74 && b == 8'h63) ||
            (a == 8'h55 && b == 8'h43) || (a == 8'h75 && b == 8'h63);
        return r;
    endfunction

endpackage

// ===== rtl/core/sws_classify.sv =====
// Column classifier: sorts one aligned character pair into gap, match, wobble or mismatch.
module sws_classify (
    input  logic [sws_pkg::CHAR_W-1:0] first_char,
    input  logic [sws_pkg::CHAR_W-1:0] second_char,
    output sws_pkg::col_class_t        col_class
);

    logic first_gap;
    logic second_gap;

    // gap detection
    assign first_gap  = (first_char == sws_pkg::GAP_CHAR);
    assign second_gap = (second_char == sws_pkg::GAP_CHAR);

    // class flags; gap takes priority downstream
    always_comb begin
        col_class.any_gap    = first_gap | second_gap;
        col_class.second_gap = second_gap;
        col_class.match      = (first_char == second_char) && sws_pkg::is_base(first_char);
        col_class.wobble     = sws_pkg::is_wobble(first_char, second_char);
    end

endmodule

// ===== rtl/core/sws_score_acc.sv =====
// Score accumulator: seed position, column penalty, running sums and the result register.
module sws_score_acc (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        col_valid,
    input  logic                        col_last,
    input  sws_pkg::col_class_t         col_class,
    input  logic [sws_pkg::CFG_W-1:0]   seed_first,
    input  logic [sws_pkg::CFG_W-1:0]   seed_last,
    input  logic                        m_ready,
    output logic                        m_valid,
    output logic [sws_pkg::SCORE_W-1:0] m_score_halves
);

    logic [sws_pkg::COUNT_W-1:0] col_pos_reg, col_pos_next;
    logic [sws_pkg::COUNT_W-1:0] gap_shift_reg, gap_shift_next;
    logic [sws_pkg::SCORE_W-1:0] sum_reg, sum_next;
    logic                        out_valid_reg, out_valid_next;
    logic [sws_pkg::SCORE_W-1:0] out_score_reg, out_score_next;

    logic [sws_pkg::COUNT_W-1:0] cnt;
    logic [sws_pkg::COUNT_W-1:0] gs;
    logic [sws_pkg::COUNT_W-1:0] pos;
    logic                        in_seed;
    logic [sws_pkg::COST_W-1:0]  cost;
    logic [sws_pkg::SCORE_W:0]   sum_wide;
    logic [sws_pkg::SCORE_W-1:0] sum_sat;

    // saturating column and gap counts, this column included
    always_comb begin
        cnt = (col_pos_reg == sws_pkg::COUNT_CAP) ? sws_pkg::COUNT_CAP
                                                   : col_pos_reg + 7'd1;
        gs  = (col_class.second_gap && gap_shift_reg != sws_pkg::COUNT_CAP)
              ? gap_shift_reg + 7'd1 : gap_shift_reg;
        pos = (gs > cnt) ? '0 : cnt - gs;
        in_seed = (pos >= seed_first) && (pos <= seed_last);
    end

    // column penalty in halves
    always_comb begin
        if (col_class.any_gap) begin
            cost = in_seed ? sws_pkg::COST_MISS_SD : sws_pkg::COST_MISS;
        end else if (col_class.match) begin
            cost = sws_pkg::COST_NONE;
        end else if (col_class.wobble) begin
            cost = in_seed ? sws_pkg::COST_WOBBLE_SD : sws_pkg::COST_WOBBLE;
        end else begin
            cost = in_seed ? sws_pkg::COST_MISS_SD : sws_pkg::COST_MISS;
        end
    end

    // saturating running sum
    always_comb begin
        sum_wide = {1'b0, sum_reg} + {{(sws_pkg::SCORE_W + 1 - sws_pkg::COST_W){1'b0}}, cost};
        sum_sat  = sum_wide[sws_pkg::SCORE_W] ? sws_pkg::SUM_CAP
                                              : sum_wide[sws_pkg::SCORE_W-1:0];
    end

    // state and result register update
    always_comb begin
        col_pos_next   = col_pos_reg;
        gap_shift_next = gap_shift_reg;
        sum_next       = sum_reg;
        out_valid_next = out_valid_reg & ~m_ready;
        out_score_next = out_score_reg;
        if (col_valid) begin
            if (col_last) begin
                col_pos_next   = '0;
                gap_shift_next = '0;
                sum_next       = '0;
                out_valid_next = 1'b1;
                out_score_next = sum_sat;
            end else begin
                col_pos_next   = cnt;
                gap_shift_next = gs;
                sum_next       = sum_sat;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_pos_reg   <= '0;
            gap_shift_reg <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            col_pos_reg   <= col_pos_next;
            gap_shift_reg <= gap_shift_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_score_reg <= out_score_next;
    end

    assign m_valid        = out_valid_reg;
    assign m_score_halves = out_score_reg;

endmodule

// ===== rtl/core/seed_weighted_alignment_scorer_core.sv =====
// Top level of the seed-weighted alignment scorer: input register, config registers, datapath.
//
// Takes one alignment column per clock while s_ready is high, and returns the total
// penalty in halves one beat per alignment, on the column flagged s_last_column.
// A column passes the input register and then one stage of classify/score logic
// into the result register; m_valid rises as the result register takes the last column.
// The running state (column count, second-sequence gap count, penalty sum) updates
// in that stage and clears after each result. Only a last column waits on the result
// register; s_ready drops when a finished score is still untaken and the next last
// column is queued. Seed bounds are written through cfg_we/cfg_addr/cfg_wdata; the
// user must write them only while idle, as the block itself does not enforce it.
module seed_weighted_alignment_scorer_core (
    input  logic                        aclk,
    input  logic                        aresetn,
    // configuration
    input  logic                        cfg_we,
    input  logic                        cfg_addr,
    input  logic [sws_pkg::CFG_W-1:0]   cfg_wdata,
    // column input
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [sws_pkg::CHAR_W-1:0]  s_first_char,
    input  logic [sws_pkg::CHAR_W-1:0]  s_second_char,
    input  logic                        s_last_column,
    // score output
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [sws_pkg::SCORE_W-1:0] m_score_halves
);

    logic [sws_pkg::CFG_W-1:0]  seed_first_reg;
    logic [sws_pkg::CFG_W-1:0]  seed_last_reg;

    logic                       in_valid_reg;
    logic [sws_pkg::CHAR_W-1:0] in_first_reg;
    logic [sws_pkg::CHAR_W-1:0] in_second_reg;
    logic                       in_last_reg;

    sws_pkg::col_class_t        col_class;
    logic                       out_free;
    logic                       consume;

    // config registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_first_reg <= sws_pkg::SEED_FIRST_RST;
            seed_last_reg  <= sws_pkg::SEED_LAST_RST;
        end else if (cfg_we) begin
            case (cfg_addr)
                sws_pkg::CFG_SEED_FIRST: seed_first_reg <= cfg_wdata;
                sws_pkg::CFG_SEED_LAST:  seed_last_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // input stage handshake
    assign out_free = ~m_valid | m_ready;
    assign consume  = in_valid_reg & (~in_last_reg | out_free);
    assign s_ready  = ~in_valid_reg | consume;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_first_reg  <= s_first_char;
            in_second_reg <= s_second_char;
            in_last_reg   <= s_last_column;
        end
    end

    sws_classify u_classify (
        .first_char  (in_first_reg),
        .second_char (in_second_reg),
        .col_class   (col_class)
    );

    sws_score_acc u_score_acc (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .col_valid      (consume),
        .col_last       (in_last_reg),
        .col_class      (col_class),
        .seed_first     (seed_first_reg),
        .seed_last      (seed_last_reg),
        .m_ready        (m_ready),
        .m_valid        (m_valid),
        .m_score_halves (m_score_halves)
    );

endmodule

// ===== verif/sws_score_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the seed-weighted alignment scorer: predicts each score and checks result beats.
module sws_score_checker
    import sws_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic               cfg_addr,
    input  logic [CFG_W-1:0]   cfg_wdata,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [CHAR_W-1:0]  s_first_char,
    input  logic [CHAR_W-1:0]  s_second_char,
    input  logic               s_last_column,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [SCORE_W-1:0] m_score_halves,
    output int                 mismatch_count,
    output int                 scores_pending
);

    localparam int REPORT_LIMIT = 10;

    // predictor copy of the seed window and the running alignment state
    logic [CFG_W-1:0]   seed_lo;
    logic [CFG_W-1:0]   seed_hi;
    logic [COUNT_W-1:0] columns_seen;
    logic [COUNT_W-1:0] second_gaps;
    logic [SCORE_W-1:0] running_penalty;

    // scores still owed by the block, oldest first
    logic [SCORE_W-1:0] score_q[$];
    int                 errors = 0;
    int                 scores_checked = 0;

    initial begin
        mismatch_count = 0;
        scores_pending = 0;
    end

    function automatic logic is_nucleotide(input logic [CHAR_W-1:0] c);
        case (c)
            "a", "c", "g", "t", "u", "A", "C", "G", "T", "U": return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    // first/second pairs that count as a wobble
    function automatic logic is_wobble_pair(input logic [CHAR_W-1:0] a,
                                            input logic [CHAR_W-1:0] b);
        case ({a, b})
            "GA", "ga", "TC", "tc", "UC", "uc": return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    // penalty of one column, in halves
    function automatic logic [COST_W-1:0] column_cost(input logic [CHAR_W-1:0] a,
                                                      input logic [CHAR_W-1:0] b,
                                                      input logic in_seed);
        if (a == GAP_CHAR || b == GAP_CHAR)
            return in_seed ? COST_MISS_SD : COST_MISS;
        if (a == b && is_nucleotide(a))
            return COST_NONE;
        if (is_wobble_pair(a, b))
            return in_seed ? COST_WOBBLE_SD : COST_WOBBLE;
        return in_seed ? COST_MISS_SD : COST_MISS;
    endfunction

    always @(posedge aclk) begin
        logic [COUNT_W:0]   cnt;
        logic [COUNT_W:0]   gaps;
        logic [COUNT_W-1:0] pos;
        logic [SCORE_W:0]   sum;
        logic               in_seed;
        logic [SCORE_W-1:0] want;
        if (!aresetn) begin
            seed_lo         = SEED_FIRST_RST;
            seed_hi         = SEED_LAST_RST;
            columns_seen    = '0;
            second_gaps     = '0;
            running_penalty = '0;
            score_q.delete();
        end else begin
            // register writes land before any later column
            if (cfg_we) begin
                if (cfg_addr == CFG_SEED_FIRST)
                    seed_lo = cfg_wdata;
                else
                    seed_hi = cfg_wdata;
            end

            // result beat against the oldest owed score
            if (m_valid && m_ready) begin
                if (score_q.size() == 0) begin
                    errors++;
                    if (errors <= REPORT_LIMIT)
                        $display("score error: unexpected beat, got %0d", m_score_halves);
                end else begin
                    want = score_q.pop_front();
                    scores_checked++;
                    if (m_score_halves !== want) begin
                        errors++;
                        if (errors <= REPORT_LIMIT)
                            $display("score error: alignment %0d expected %0d, got %0d",
                                     scores_checked, want, m_score_halves);
                    end
                end
            end

            // column beat: advance the running state
            if (s_valid && s_ready) begin
                cnt = columns_seen + 1'b1;
                if (cnt > COUNT_CAP)
                    cnt = COUNT_CAP;
                gaps = second_gaps + (s_second_char == GAP_CHAR);
                if (gaps > COUNT_CAP)
                    gaps = COUNT_CAP;
                pos     = (gaps > cnt) ? '0 : COUNT_W'(cnt - gaps);
                in_seed = (pos >= seed_lo) && (pos <= seed_hi);
                sum     = running_penalty + column_cost(s_first_char, s_second_char, in_seed);
                if (sum > SUM_CAP)
                    sum = SUM_CAP;
                if (s_last_column) begin
                    score_q.push_back(sum[SCORE_W-1:0]);
                    columns_seen    = '0;
                    second_gaps     = '0;
                    running_penalty = '0;
                end else begin
                    columns_seen    = cnt[COUNT_W-1:0];
                    second_gaps     = gaps[COUNT_W-1:0];
                    running_penalty = sum[SCORE_W-1:0];
                end
            end
        end
        mismatch_count <= errors;
        scores_pending <= score_q.size();
    end

endmodule

// ===== verif/tb_seed_weighted_alignment_scorer_core.sv =====
`timescale 1ns / 1ps
// Testbench top: clock, reset, column stimulus, result backpressure and the verdict.
module tb_seed_weighted_alignment_scorer_core;
    import sws_pkg::*;

    localparam int HALF_PERIOD_NS = 6;
    localparam int RESET_CYCLES   = 8;
    localparam int HOLD_CYCLES    = 300;
    localparam int IDLE_LIMIT     = 4000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int PHASES         = 10;
    localparam int PHASE_COLUMNS  = 68;
    localparam int BURST_SCORES   = 48;

    logic               aclk;
    logic               aresetn;
    logic               cfg_we;
    logic               cfg_addr;
    logic [CFG_W-1:0]   cfg_wdata;
    logic               s_valid;
    logic               s_ready;
    logic [CHAR_W-1:0]  s_first_char;
    logic [CHAR_W-1:0]  s_second_char;
    logic               s_last_column;
    logic               m_valid;
    logic               m_ready;
    logic [SCORE_W-1:0] m_score_halves;

    int mismatch_count;
    int scores_pending;
    int columns_sent  = 0;
    int tx_idle_pct   = 0;
    int rx_stall_pct  = 0;
    int hold_requests = 0;
    int idle_cycles   = 0;

    seed_weighted_alignment_scorer_core dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_first_char   (s_first_char),
        .s_second_char  (s_second_char),
        .s_last_column  (s_last_column),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_score_halves (m_score_halves)
    );

    sws_score_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_first_char   (s_first_char),
        .s_second_char  (s_second_char),
        .s_last_column  (s_last_column),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_score_halves (m_score_halves),
        .mismatch_count (mismatch_count),
        .scores_pending (scores_pending)
    );

    initial aclk = 1'b0;
    always #HALF_PERIOD_NS aclk = ~aclk;

    // watchdog: too long without any beat on either channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // result side: random stalls, plus a long counted hold-off on request
    initial begin
        int holds_served;
        holds_served = 0;
        m_ready = 1'b0;
        forever begin
            @(posedge aclk);
            if (holds_served != hold_requests) begin
                holds_served++;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    function automatic logic [CHAR_W-1:0] pick_base();
        case ($urandom_range(9))
            0: return "a";
            1: return "c";
            2: return "g";
            3: return "t";
            4: return "u";
            5: return "A";
            6: return "C";
            7: return "G";
            8: return "T";
            default: return "U";
        endcase
    endfunction

    function automatic logic [2*CHAR_W-1:0] pick_wobble();
        case ($urandom_range(5))
            0: return "GA";
            1: return "ga";
            2: return "TC";
            3: return "tc";
            4: return "UC";
            default: return "uc";
        endcase
    endfunction

    // one column drawn from a mix of matches, wobbles, gaps and raw bytes
    function automatic void random_column(output logic [CHAR_W-1:0] a,
                                          output logic [CHAR_W-1:0] b);
        int                  kind;
        logic [2*CHAR_W-1:0] pair;
        kind = $urandom_range(99);
        if (kind < 25) begin
            a = pick_base();
            b = a;
        end else if (kind < 43) begin
            pair = pick_wobble();
            a = pair[2*CHAR_W-1:CHAR_W];
            b = pair[CHAR_W-1:0];
        end else if (kind < 53) begin
            a = GAP_CHAR;
            b = pick_base();
        end else if (kind < 68) begin
            a = $urandom_range(1) ? pick_base() : CHAR_W'($urandom);
            b = GAP_CHAR;
        end else if (kind < 73) begin
            a = GAP_CHAR;
            b = GAP_CHAR;
        end else if (kind < 85) begin
            a = pick_base();
            b = pick_base();
        end else begin
            a = CHAR_W'($urandom);
            b = CHAR_W'($urandom);
        end
    endfunction

    // offer one column beat and hold it until taken
    task automatic send_column(input logic [CHAR_W-1:0] a, input logic [CHAR_W-1:0] b,
                               input logic last);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_first_char  <= a;
        s_second_char <= b;
        s_last_column <= last;
        do @(posedge aclk); while (!s_ready);
        columns_sent++;
    endtask

    // whole alignment; optionally every column has a gap in the second sequence
    task automatic send_alignment(input int len, input logic second_gaps_only);
        logic [CHAR_W-1:0] a;
        logic [CHAR_W-1:0] b;
        for (int i = 0; i < len; i++) begin
            random_column(a, b);
            if (second_gaps_only)
                b = GAP_CHAR;
            send_column(a, b, i == len - 1);
        end
    endtask

    // drain the block, then rewrite both seed bounds
    task automatic write_seed_window(input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (scores_pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_SEED_FIRST;
        cfg_wdata <= lo;
        @(posedge aclk);
        cfg_addr  <= CFG_SEED_LAST;
        cfg_wdata <= hi;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    initial begin
        logic [CFG_W-1:0] lo;
        logic [CFG_W-1:0] hi;
        int               start;
        aresetn       = 1'b0;
        cfg_we        = 1'b0;
        cfg_addr      = CFG_SEED_FIRST;
        cfg_wdata     = '0;
        s_valid       = 1'b0;
        s_first_char  = '0;
        s_second_char = '0;
        s_last_column = 1'b0;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // directed columns under the reset seed window
        send_column("A", "A", 1'b0);
        send_column("G", "A", 1'b0);
        send_column("g", "a", 1'b0);
        send_column("T", "C", 1'b0);
        send_column("t", "c", 1'b0);
        send_column("U", "C", 1'b0);
        send_column("u", "c", 1'b0);
        send_column("a", "a", 1'b0);
        send_column("c", "c", 1'b0);
        send_column("g", "g", 1'b0);
        send_column("t", "t", 1'b0);
        send_column("u", "u", 1'b0);
        send_column("C", "C", 1'b0);
        send_column("G", "G", 1'b0);
        send_column("T", "T", 1'b0);
        send_column("U", "U", 1'b0);
        send_column(GAP_CHAR, "a", 1'b0);
        send_column("a", GAP_CHAR, 1'b0);
        send_column(GAP_CHAR, GAP_CHAR, 1'b0);
        send_column(8'h00, 8'hff, 1'b0);
        send_column(8'hff, 8'hff, 1'b0);
        send_column("G", "g", 1'b0);
        send_column("A", "G", 1'b0);
        send_column(8'h80, 8'h7f, 1'b1);
        send_column("a", "a", 1'b1);

        // random phases, each with its own seed window and idle pattern
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin lo = 7'd0;   hi = 7'd127; end
                1: begin lo = 7'd0;   hi = 7'd0;   end
                2: begin lo = 7'd127; hi = 7'd127; end
                3: begin lo = 7'd64;  hi = 7'd64;  end
                4: begin lo = 7'd10;  hi = 7'd3;   end
                5: begin lo = 7'd127; hi = 7'd0;   end
                6: begin lo = 7'd2;   hi = 7'd8;   end
                7: begin lo = 7'd1;   hi = 7'd20;  end
                default: begin
                    lo = CFG_W'($urandom_range(127));
                    hi = CFG_W'($urandom_range(127));
                end
            endcase
            write_seed_window(lo, hi);

            case (phase % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct <= 0;  end
                1: begin tx_idle_pct = 78; rx_stall_pct <= 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct <= 78; end
                default: begin tx_idle_pct = 33; rx_stall_pct <= 33; end
            endcase

            // overlong alignments drive the counters and the sum into saturation
            if (phase == 0)
                send_alignment(140, 1'b1);
            if (phase == 2)
                send_alignment(150, 1'b0);

            // result side holds off while single-column alignments keep coming
            if (phase == 4) begin
                hold_requests <= hold_requests + 1;
                repeat (BURST_SCORES) send_alignment(1, 1'b0);
            end

            start = columns_sent;
            while (columns_sent - start < PHASE_COLUMNS) begin
                if ($urandom_range(9) == 0)
                    send_alignment($urandom_range(20, 70), 1'b0);
                else
                    send_alignment($urandom_range(1, 20), 1'b0);
            end
        end

        // wait for every owed score and a quiet drain, then report the verdict
        s_valid <= 1'b0;
        @(posedge aclk);
        while (scores_pending != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && scores_pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
